/* design/bitmap_id_allocator_defines.svh */
// Assertion macros shared by the bitmap id allocator modules.
// Depends on nothing; users must have aclk and aresetn in scope.
`ifndef BITMAP_ID_ALLOCATOR_DEFINES_SVH
`define BITMAP_ID_ALLOCATOR_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define BIA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bitmap id allocator: same-cycle check failed");

// Condition implies consequence in the next cycle.
`define BIA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bitmap id allocator: next-cycle check failed");

`endif

/* design/bia_pkg.sv */
// Shared constants, result codes and controller/datapath interface types
// for the bitmap id allocator. Depends on nothing.
`timescale 1ns / 1ps

package bia_pkg;

    // Bitmap geometry.
    localparam int NUM_IDS   = 4096;
    localparam int WORD_BITS = 64;
    localparam int MAP_WORDS = (NUM_IDS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_AW    = $clog2(WORD_BITS);
    localparam int SLOT_W    = WORD_AW + BIT_AW;

    // Identifier fields.
    localparam int ID_W = 16;
    localparam logic [ID_W-1:0] BASE_RESET = 16'd300;
    localparam logic [ID_W:0]   ID_LIMIT   = 17'(NUM_IDS);

    // Result codes.
    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_NONE_FREE = 2'd1,
        ST_RELEASED  = 2'd2,
        ST_INVALID   = 2'd3
    } bia_status_t;

    // Request kinds.
    localparam logic OP_ALLOCATE = 1'b0;
    localparam logic OP_RELEASE  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;      // latch the request payload
        logic scan_clear;   // restart the word scan at word zero
        logic scan_step;    // read the scan word and advance
        logic rd_rel;       // read the word holding the release slot
        logic alloc_commit; // set the found bit, record an allocation
        logic none_free;    // record that no id is free
        logic rel_commit;   // clear the release bit, record a release
        logic rel_invalid;  // record an out-of-range release
        logic out_load;     // move the recorded result to the output
    } bia_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic word_hit;    // the word under test has a free bit
        logic slot_ok;     // that free bit maps to a usable id
        logic last_word;   // the word under test is the last one
        logic id_in_range; // the release id lies inside the map
        logic out_free;    // the output register can take a result
    } bia_stat_t;

endpackage

/* design/bia_datapath.sv */
// Datapath of the bitmap id allocator: bitmap memory with per-row valid
// bits, word scan, first-free search, id arithmetic and output register.
// Depends on bia_pkg and bitmap_id_allocator_defines.svh.
`timescale 1ns / 1ps
`include "bitmap_id_allocator_defines.svh"

module bia_datapath import bia_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  bia_cmd_t          cmd,
    output bia_stat_t         stat,
    input  logic [ID_W-1:0]   req_id,
    input  logic              cfg_wr_en,
    input  logic [ID_W-1:0]   cfg_wr_data,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [1:0]        m_status,
    output logic [ID_W-1:0]   m_granted
);

    // Lowest set bit of a word, found by halving the window six times.
    function automatic logic [BIT_AW-1:0] find_first(input logic [WORD_BITS-1:0] bits);
        logic [WORD_BITS-1:0] v;
        logic [BIT_AW-1:0]    idx;
        int                   half;
        v   = bits;
        idx = '0;
        for (int k = BIT_AW - 1; k >= 0; k--) begin
            half = 1 << k;
            if ((v & ((WORD_BITS'(1) << half) - WORD_BITS'(1))) == '0) begin
                v      = v >> half;
                idx[k] = 1'b1;
            end
        end
        return idx;
    endfunction

    logic [ID_W-1:0]      base_reg;
    logic [ID_W-1:0]      cap_id_reg;
    logic [WORD_AW-1:0]   scan_reg;
    logic [WORD_AW-1:0]   rd_addr_reg;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_valid_reg;
    logic [MAP_WORDS-1:0] row_valid_reg;
    logic [WORD_BITS-1:0] map_mem [MAP_WORDS];

    logic [1:0]           pend_status_reg;
    logic [ID_W-1:0]      pend_granted_reg;
    logic                 m_valid_reg;
    logic [1:0]           m_status_reg;
    logic [ID_W-1:0]      m_granted_reg;

    logic [ID_W:0]        rel_diff;
    logic [SLOT_W-1:0]    rel_slot;
    logic [WORD_AW-1:0]   rel_word;
    logic [BIT_AW-1:0]    rel_bit;
    logic [WORD_AW-1:0]   rd_addr;
    logic [WORD_BITS-1:0] eff_word;
    logic [WORD_BITS-1:0] free_bits;
    logic [BIT_AW-1:0]    hit_bit;
    logic [SLOT_W-1:0]    hit_slot;
    logic [ID_W:0]        hit_sum;
    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;

    // Release id to slot; ids below the base or past the map are rejected.
    assign rel_diff = {1'b0, cap_id_reg} - {1'b0, base_reg};
    assign rel_slot = rel_diff[SLOT_W-1:0];
    assign rel_word = rel_slot[SLOT_W-1:BIT_AW];
    assign rel_bit  = rel_slot[BIT_AW-1:0];
    assign stat.id_in_range = !rel_diff[ID_W] && ({1'b0, rel_diff[ID_W-1:0]} < ID_LIMIT);

    // The single read port serves either the scan or the release word.
    assign rd_addr = cmd.rd_rel ? rel_word : scan_reg;

    // A row never written since reset reads as all free.
    assign eff_word  = rd_valid_reg ? rd_data_reg : '0;
    assign free_bits = ~eff_word;
    assign hit_bit   = find_first(free_bits);
    assign hit_slot  = {rd_addr_reg, hit_bit};
    assign hit_sum   = {1'b0, base_reg} + (ID_W + 1)'(hit_slot);

    assign stat.word_hit  = |free_bits;
    assign stat.slot_ok   = ((ID_W + 1)'(hit_slot) < ID_LIMIT) && !hit_sum[ID_W];
    assign stat.last_word = (rd_addr_reg == WORD_AW'(MAP_WORDS - 1));
    assign stat.out_free  = !m_valid_reg || m_tready;

    // Write back the word just read with one bit set or cleared.
    assign wr_en   = cmd.alloc_commit || cmd.rel_commit;
    assign wr_data = cmd.alloc_commit ? (eff_word | (WORD_BITS'(1) << hit_bit))
                                      : (eff_word & ~(WORD_BITS'(1) << rel_bit));

    // Bitmap memory: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            map_mem[rd_addr_reg] <= wr_data;
        end
        rd_data_reg  <= map_mem[rd_addr];
        rd_valid_reg <= row_valid_reg[rd_addr];
        rd_addr_reg  <= rd_addr;
    end

    // Control registers: row valid bits, base id, output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            base_reg      <= BASE_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            if (wr_en) begin
                row_valid_reg[rd_addr_reg] <= 1'b1;
            end
            if (cfg_wr_en) begin
                base_reg <= cfg_wr_data;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: request, scan pointer, recorded and output result.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cap_id_reg <= req_id;
        end
        if (cmd.scan_clear) begin
            scan_reg <= '0;
        end else if (cmd.scan_step) begin
            scan_reg <= scan_reg + WORD_AW'(1);
        end
        if (cmd.alloc_commit) begin
            pend_status_reg  <= ST_ALLOCATED;
            pend_granted_reg <= hit_sum[ID_W-1:0];
        end else if (cmd.none_free) begin
            pend_status_reg  <= ST_NONE_FREE;
            pend_granted_reg <= '0;
        end else if (cmd.rel_commit) begin
            pend_status_reg  <= ST_RELEASED;
            pend_granted_reg <= '0;
        end else if (cmd.rel_invalid) begin
            pend_status_reg  <= ST_INVALID;
            pend_granted_reg <= '0;
        end
        if (cmd.out_load) begin
            m_status_reg  <= pend_status_reg;
            m_granted_reg <= pend_granted_reg;
        end
    end

    assign m_tvalid  = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_granted = m_granted_reg;

    // Checks on commit conditions and on the granted id of a result.
    `BIA_ASSERT_IMP(a_alloc_on_hit, cmd.alloc_commit, stat.word_hit && stat.slot_ok)
    `BIA_ASSERT_IMP(a_release_in_range, cmd.rel_commit, stat.id_in_range)
    `BIA_ASSERT_IMP(a_granted_zero, m_valid_reg && (m_status_reg != ST_ALLOCATED),
                    m_granted_reg == '0)

endmodule

/* design/bia_ctrl.sv */
// Controller of the bitmap id allocator: sequences one request through
// scan or read-modify-write and hands the result to the output register.
// Depends on bia_pkg and bitmap_id_allocator_defines.svh.
`timescale 1ns / 1ps
`include "bitmap_id_allocator_defines.svh"

module bia_ctrl import bia_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic      req_opcode,
    input  bia_stat_t stat,
    output bia_cmd_t  cmd
);

    typedef enum logic [2:0] {
        IDLE,
        SCAN_START,
        SCAN,
        REL_CHK,
        REL_WR,
        RESP
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands for the datapath.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            IDLE: begin
                // No request is taken while reset is held.
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.capture = 1'b1;
                    if (req_opcode == OP_RELEASE) begin
                        state_next = REL_CHK;
                    end else begin
                        cmd.scan_clear = 1'b1;
                        state_next     = SCAN_START;
                    end
                end
            end
            SCAN_START: begin
                cmd.scan_step = 1'b1;
                state_next    = SCAN;
            end
            SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.word_hit) begin
                    if (stat.slot_ok) begin
                        cmd.alloc_commit = 1'b1;
                    end else begin
                        cmd.none_free = 1'b1;
                    end
                    state_next = RESP;
                end else if (stat.last_word) begin
                    cmd.none_free = 1'b1;
                    state_next    = RESP;
                end
            end
            REL_CHK: begin
                cmd.rd_rel = 1'b1;
                if (stat.id_in_range) begin
                    state_next = REL_WR;
                end else begin
                    cmd.rel_invalid = 1'b1;
                    state_next      = RESP;
                end
            end
            REL_WR: begin
                cmd.rel_commit = 1'b1;
                state_next     = RESP;
            end
            RESP: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // A result leaves only into a free output slot, and every request
    // records exactly one outcome before it reaches the result state.
    `BIA_ASSERT_IMP(a_load_when_free, cmd.out_load, stat.out_free)
    `BIA_ASSERT_NEXT(a_outcome_then_resp,
                     cmd.alloc_commit || cmd.none_free || cmd.rel_commit || cmd.rel_invalid,
                     state_reg == RESP)
    `BIA_ASSERT_IMP(a_one_outcome, 1'b1,
                    $onehot0({cmd.alloc_commit, cmd.none_free, cmd.rel_commit,
                              cmd.rel_invalid}))

endmodule

/* design/bitmap_id_allocator.sv */
// Bitmap first-free identifier allocator. An allocate request returns the
// lowest free id at or above base_id (status allocated) or status none
// free; a release request frees an id in base_id .. base_id+4095 (status
// released, also when it was already free) or answers invalid id. The
// bitmap sits in a 64-word by 64-bit memory with one read port, so an
// allocate reads the words in turn until a free bit is found (at most 64
// words); a release reads the word holding its slot and writes it back
// with the bit cleared, or answers invalid id when the id is out of
// range. One request is worked on at a time; a new request is accepted
// while the previous result still waits in the output register, and its
// own result then waits until the output register is free. Reset clears
// the map at once through one valid bit per memory row, so there is no
// clearing pass. base_id must be written through cfg_wr_en/cfg_wr_data
// only while no request is pending; the block does not enforce this.
// Depends on bia_pkg, bia_ctrl and bia_datapath.
`timescale 1ns / 1ps

module bitmap_id_allocator import bia_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] release_id
    input  logic [0:0]  s_tuser,    // [0] opcode
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] granted_id
    output logic [1:0]  m_tuser,    // [1:0] status
    // Base id register.
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    bia_cmd_t  cmd;
    bia_stat_t stat;

    // Request sequencing.
    bia_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .req_opcode (s_tuser[0]),
        .stat       (stat),
        .cmd        (cmd)
    );

    // Bitmap storage, search and result registers.
    bia_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .req_id      (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_status    (m_tuser),
        .m_granted   (m_tdata)
    );

endmodule

/* bench/bitmap_id_allocator_tb.sv */
// Self-checking bench for bitmap_id_allocator: random and directed id requests over
// the stream ports, checked against a behavioral bitmap predictor held in the bench.
// Depends on bia_pkg and the bitmap_id_allocator RTL.
`timescale 1ns / 1ps

module bitmap_id_allocator_tb;
    import bia_pkg::*;

    typedef struct {
        logic        op;
        logic [15:0] id;
    } id_request_t;

    typedef struct {
        bia_status_t status;
        logic [15:0] id;
    } id_result_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata     = '0;
    logic [0:0]  s_tuser     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;

    // Requests waiting to be offered, and results predicted but not yet seen.
    id_request_t request_q[$];
    id_result_t  grant_q[$];

    // Bench copy of the allocator state.
    bit          used_map [NUM_IDS];
    logic [15:0] model_base = BASE_RESET;
    int          granted_slots[$];

    int          err_count      = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_reqs      = 0;
    int          hold_seen      = 0;
    int          stall_left     = 0;
    id_request_t drv_item;
    id_result_t  want;

    bitmap_id_allocator i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #1 aclk = ~aclk;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        err_count++;
    endtask

    // Apply one accepted request to the bitmap and queue the result it should give.
    task automatic predict_grant(input logic op, input logic [15:0] id);
        id_result_t r;
        int         lim;
        int         slot;
        r.status = ST_NONE_FREE;
        r.id     = '0;
        if (op == OP_ALLOCATE) begin
            // Slots whose id would pass 16 bits are never handed out.
            lim  = (int'(model_base) + NUM_IDS > 65536) ? 65536 - int'(model_base) : NUM_IDS;
            slot = 0;
            while (slot < NUM_IDS && used_map[slot]) slot++;
            if (slot < lim) begin
                used_map[slot] = 1'b1;
                r.status = ST_ALLOCATED;
                r.id     = 16'(int'(model_base) + slot);
                granted_slots.push_back(slot);
                if (granted_slots.size() > 1024) void'(granted_slots.pop_front());
            end
        end else if (id < model_base || int'(id) - int'(model_base) >= NUM_IDS) begin
            r.status = ST_INVALID;
        end else begin
            // Releasing a slot that is already free still reports success.
            used_map[int'(id) - int'(model_base)] = 1'b0;
            r.status = ST_RELEASED;
        end
        grant_q.push_back(r);
    endtask

    // Request driver: offers queued requests, predicting each one as it is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_grant(s_tuser[0], s_tdata);
            if (!s_tvalid || s_tready) begin
                if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv_item = request_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= drv_item.op;
                    s_tdata  <= drv_item.id;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each accepted result and shapes backpressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (grant_q.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = grant_q.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_tuser, want.status));
                    if (m_tdata !== want.id)
                        report_mismatch($sformatf("granted id %0d, expected %0d",
                                                  m_tdata, want.id));
                end
            end
            // A long hold-off lets the block fill up and stall its input.
            if (hold_reqs != hold_seen) begin
                hold_seen  = hold_reqs;
                stall_left = 400;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic push_request(input logic op, input logic [15:0] id);
        id_request_t q;
        q.op = op;
        q.id = id;
        while (request_q.size() >= 4) @(negedge aclk);
        request_q.push_back(q);
    endtask

    // Mostly allocations and releases of ids handed out earlier, plus edge and noise ids.
    task automatic push_random_request();
        int unsigned sel;
        int          k;
        logic [15:0] rid;
        sel = $urandom_range(99);
        rid = 16'($urandom);
        if (sel < 55) begin
            push_request(OP_ALLOCATE, rid);
        end else begin
            sel = $urandom_range(99);
            if (sel < 50 && granted_slots.size() > 0) begin
                k   = $urandom_range(granted_slots.size() - 1);
                rid = 16'(int'(model_base) + granted_slots[k]);
                granted_slots.delete(k);
            end else if (sel < 75) begin
                rid = 16'(int'(model_base) + $urandom_range(127));
            end else if (sel < 87) begin
                rid = $urandom_range(1) ? 16'(int'(model_base) - 1)
                                        : 16'(int'(model_base) + NUM_IDS);
            end
            push_request(OP_RELEASE, rid);
        end
    endtask

    // Wait until nothing is queued, offered or outstanding.
    task automatic wait_idle();
        @(negedge aclk);
        while (request_q.size() != 0 || s_tvalid || grant_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_base(input logic [15:0] value);
        wait_idle();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        model_base = value;
    endtask

    initial begin
        logic [15:0] phase_base [6];
        int          mode;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests at the reset base.
        push_request(OP_RELEASE, 16'd300);        // release of a free id
        push_request(OP_ALLOCATE, 16'd0);
        push_request(OP_ALLOCATE, 16'hFFFF);      // payload ignored on allocate
        push_request(OP_RELEASE, 16'd299);        // just below the range
        push_request(OP_RELEASE, 16'd4396);       // just above the range
        push_request(OP_RELEASE, 16'd4395);       // top slot
        push_request(OP_RELEASE, 16'd0);
        push_request(OP_RELEASE, 16'hFFFF);
        push_request(OP_RELEASE, 16'd300);
        push_request(OP_ALLOCATE, 16'h5555);
        push_request(OP_ALLOCATE, 16'hAAAA);

        // Lowest base: the map is kept, so old slots now mean new ids.
        write_base(16'd0);
        push_request(OP_RELEASE, 16'd0);
        push_request(OP_RELEASE, 16'd4095);
        push_request(OP_RELEASE, 16'd4096);
        push_request(OP_ALLOCATE, 16'd0);

        // Base at which the top slot maps to id 65534.
        write_base(16'd61439);
        push_request(OP_RELEASE, 16'hFFFF);
        push_request(OP_RELEASE, 16'hFFFE);
        push_request(OP_ALLOCATE, 16'd0);

        // Base near the top of the id space: only six slots can be handed out.
        write_base(16'd65530);
        repeat (6) push_request(OP_ALLOCATE, 16'd0);
        push_request(OP_RELEASE, 16'hFFFF);
        push_request(OP_RELEASE, 16'd65529);
        push_request(OP_ALLOCATE, 16'd0);

        // Random phases under different bases and idling patterns.
        phase_base[0] = BASE_RESET;
        phase_base[1] = 16'd0;
        phase_base[2] = 16'($urandom_range(61439));
        phase_base[3] = 16'd61439;
        phase_base[4] = 16'd65500;
        phase_base[5] = 16'($urandom_range(61439));
        for (int p = 0; p < 6; p++) begin
            write_base(phase_base[p]);
            mode = p % 4;
            send_idle_pct  = (mode == 1) ? 69 : (mode == 3) ? 20 : 0;
            recv_stall_pct = (mode == 2) ? 69 : (mode == 3) ? 20 : 0;
            for (int n = 0; n < 200; n++) begin
                if (p == 0 && n == 50) hold_reqs++;
                push_random_request();
            end
        end

        wait_idle();
        repeat (20) @(negedge aclk);
        if (grant_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", grant_q.size()));
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog in case the block stops answering.
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
